@@ design/cst_pkg.sv @@
// Shared types and constants for the Collatz stopping-time block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Fixed widths of the port fields
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_USER_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    // Defaults for the top-level parameters
    localparam int NUMBER_WIDTH_DEF = 128;
    localparam int STEP_WIDTH_DEF   = 32;

    // Reset value of the step limit register
    localparam logic [CFG_DATA_W-1:0] STEP_LIMIT_RST = 32'd100000;

    // Register index taken from paddr
    typedef enum logic {
        REG_STEP_LIMIT = 1'b0,
        REG_UNUSED     = 1'b1
    } t_reg_idx;

    // End-of-run status, sent on tuser
    typedef enum logic [OUT_USER_W-1:0] {
        OC_ONE   = 2'd0,
        OC_CYCLE = 2'd1,
        OC_OVF   = 2'd2,
        OC_LIMIT = 2'd3
    } t_outcome;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SLOW  = 5'b00010,
        ST_FAST1 = 5'b00100,
        ST_FAST2 = 5'b01000,
        ST_WAIT  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

@@ design/cst_step_unit.sv @@
// Shared Collatz step unit: halve when even, 3n+1 when odd, with overflow flag.
// Depends on cst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cst_step_unit #(
    parameter int W = cst_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic [W-1:0] i_value,
    output logic      [W-1:0] o_next,
    output logic              o_ovf
);
    import cst_pkg::*;

    logic [W+1:0] w_triple;

    // 3n+1 as (n << 1) + n + 1, two guard bits catch the overflow
    assign w_triple = {1'b0, i_value, 1'b0} + {2'b00, i_value} + {{(W+1){1'b0}}, 1'b1};

    // Select halving or 3n+1 on the low bit
    always_comb begin
        if (i_value[0]) begin
            o_next = w_triple[W-1:0];
            o_ovf  = |w_triple[W+1:W];
        end else begin
            o_next = {1'b0, i_value[W-1:1]};
            o_ovf  = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ design/cst_apb_regs.sv @@
// APB register file holding the step limit.
// Depends on cst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cst_apb_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cst_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [cst_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [cst_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [cst_pkg::CFG_DATA_W-1:0]  o_step_limit
);
    import cst_pkg::*;

    logic [CFG_DATA_W-1:0] r_step_limit;
    t_reg_idx              w_idx;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    // Write the step limit on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= STEP_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && (w_idx == REG_STEP_LIMIT)) begin
            r_step_limit <= pwdata;
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_STEP_LIMIT: prdata = r_step_limit;
            default:        prdata = '0;
        endcase
    end

    assign o_step_limit = r_step_limit;

endmodule

`default_nettype wire

@@ design/collatz_stopping_time_top.sv @@
// Collatz total stopping time with cycle check: one starting number in, one
// step count and status out. A single shared Collatz step unit serves the slow
// copy and both fast-copy steps in turn under a five-state sequencer. An item
// passes through accept, the steps and the hand-over to the output register;
// the input side is not ready during that time but may take a new request
// while a finished result still waits on the output. Status on tuser: reached
// one, cycle detected, 3n+1 overflow, or step limit hit.
// Depends on cst_pkg, cst_step_unit and cst_apb_regs.
`timescale 1ns / 1ps
`default_nettype none

module collatz_stopping_time_top #(
    parameter int NUMBER_WIDTH = cst_pkg::NUMBER_WIDTH_DEF,
    parameter int STEP_WIDTH   = cst_pkg::STEP_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: start_low [63:0], start_high [127:64]
    input  wire logic [cst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: step_count [31:0]
    output logic      [cst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: outcome [1:0]
    output logic      [cst_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cst_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [cst_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [cst_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import cst_pkg::*;

    // Compare width covers both the counter and the 32-bit limit
    localparam int CW = (STEP_WIDTH > CFG_DATA_W) ? STEP_WIDTH : CFG_DATA_W;

    t_state                  r_state, n_state;
    t_outcome                r_res_oc, n_res_oc;
    logic [NUMBER_WIDTH-1:0] r_slow, n_slow;
    logic [NUMBER_WIDTH-1:0] r_fast, n_fast;
    logic [STEP_WIDTH-1:0]   r_steps, n_steps;
    logic [OUT_DATA_W-1:0]   r_out_count;
    t_outcome                r_out_oc;
    logic                    r_out_valid;

    logic [CFG_DATA_W-1:0]   w_step_limit;
    logic [CW-1:0]           w_limit_x, w_max_x, w_limit_eff, w_steps_x;
    logic [NUMBER_WIDTH-1:0] w_start, w_operand, w_next, w_fast_new;
    logic                    w_ovf, w_slow_one, w_fast_one, w_out_load;

    // Configuration registers
    cst_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_step_limit (w_step_limit)
    );

    // Shared step unit: slow copy in the slow state, fast copy otherwise
    assign w_operand = (r_state == ST_SLOW) ? r_slow : r_fast;

    cst_step_unit #(
        .W (NUMBER_WIDTH)
    ) u_step (
        .i_value (w_operand),
        .o_next  (w_next),
        .o_ovf   (w_ovf)
    );

    // Cap the limit at the largest counter value
    assign w_limit_x   = CW'(w_step_limit);
    assign w_max_x     = CW'({STEP_WIDTH{1'b1}});
    assign w_limit_eff = (w_limit_x > w_max_x) ? w_max_x : w_limit_x;
    assign w_steps_x   = CW'(r_steps);

    assign w_start    = s_axis_tdata[NUMBER_WIDTH-1:0];
    assign w_slow_one = (r_slow == NUMBER_WIDTH'(1));
    assign w_fast_one = (r_fast == NUMBER_WIDTH'(1));
    assign w_fast_new = w_fast_one ? r_fast : w_next;
    assign w_out_load = (r_state == ST_WAIT) && (!r_out_valid || m_axis_tready);

    // Sequencer: slow step, two fast steps, then the meeting check
    always_comb begin
        n_state  = r_state;
        n_res_oc = r_res_oc;
        n_slow   = r_slow;
        n_fast   = r_fast;
        n_steps  = r_steps;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_slow  = w_start;
                    n_fast  = w_start;
                    n_steps = '0;
                    n_state = ST_SLOW;
                end
            end
            ST_SLOW: begin
                if (w_slow_one) begin
                    n_res_oc = OC_ONE;
                    n_state  = ST_WAIT;
                end else if (w_steps_x >= w_limit_eff) begin
                    n_res_oc = OC_LIMIT;
                    n_state  = ST_WAIT;
                end else begin
                    n_steps = r_steps + STEP_WIDTH'(1);
                    n_slow  = w_next;
                    if (w_ovf) begin
                        n_res_oc = OC_OVF;
                        n_state  = ST_WAIT;
                    end else begin
                        n_state = ST_FAST1;
                    end
                end
            end
            ST_FAST1: begin
                if (!w_fast_one && w_ovf) begin
                    n_res_oc = OC_OVF;
                    n_state  = ST_WAIT;
                end else begin
                    n_fast  = w_fast_new;
                    n_state = ST_FAST2;
                end
            end
            ST_FAST2: begin
                if (!w_fast_one && w_ovf) begin
                    n_res_oc = OC_OVF;
                    n_state  = ST_WAIT;
                end else begin
                    n_fast = w_fast_new;
                    if ((r_slow == w_fast_new) && !w_slow_one) begin
                        n_res_oc = OC_CYCLE;
                        n_state  = ST_WAIT;
                    end else begin
                        n_state = ST_SLOW;
                    end
                end
            end
            ST_WAIT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working copies and counter
    always_ff @(posedge i_clk) begin
        r_res_oc <= n_res_oc;
        r_slow   <= n_slow;
        r_fast   <= n_fast;
        r_steps  <= n_steps;
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= w_steps_x[OUT_DATA_W-1:0];
            r_out_oc    <= r_res_oc;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;
    assign m_axis_tuser  = r_out_oc;

`ifndef SYNTHESIS
    // Counter never passes the capped limit while a run is in progress
    a_steps_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (w_steps_x <= w_limit_eff))
        else $error("step counter beyond limit");

    // A limit result carries the limit itself as count
    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == OC_LIMIT))
            |-> (m_axis_tdata == w_limit_eff[OUT_DATA_W-1:0]))
        else $error("limit result with wrong count");

    // Cycle and overflow need at least one step
    a_nonzero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tuser == OC_CYCLE) || (m_axis_tuser == OC_OVF)))
            |-> (m_axis_tdata != '0))
        else $error("cycle or overflow with zero count");

    // Fast copy stays at one once it gets there
    a_fast_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((r_state == ST_FAST1) || (r_state == ST_FAST2)) && w_fast_one) |=> w_fast_one)
        else $error("fast copy left one");
`endif

endmodule

`default_nettype wire
